@@ sv/nfs_pkg.sv @@
// ----------------------------------------------------------------------------
// nfs_pkg
// Shared types and the sine table generator of the complex frequency shifter.
// ----------------------------------------------------------------------------
package nfs_pkg;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } nfs_quad_t;

  typedef struct packed {
    logic valid;
    logic block_end;
  } nfs_ctrl_t;

  typedef struct packed {
    logic take;
    logic restart;
  } nfs_phase_ctl_t;

  // quarter-wave sine entry: Taylor series in unsigned Q2.30, rounded to sample width
  function automatic logic [23:0] nfs_sine_entry(input int unsigned k,
                                                 input int unsigned tab_bits,
                                                 input int unsigned sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] smax;
    x    = (HALF_PI_Q30 * 64'(k)) >> tab_bits;
    x2   = (x * x) >> 30;
    acc  = ONE_Q30;
    acc  = ONE_Q30 - (((x2 * acc) >> 30) / 64'd156);
    acc  = ONE_Q30 - (((x2 * acc) >> 30) / 64'd110);
    acc  = ONE_Q30 - (((x2 * acc) >> 30) / 64'd72);
    acc  = ONE_Q30 - (((x2 * acc) >> 30) / 64'd42);
    acc  = ONE_Q30 - (((x2 * acc) >> 30) / 64'd20);
    acc  = ONE_Q30 - (((x2 * acc) >> 30) / 64'd6);
    v    = (x * acc) >> 30;
    smax = (64'd1 << (sample_bits - 1)) - 64'd1;
    r    = (v + (64'd1 << (30 - sample_bits))) >> (31 - sample_bits);
    if (r > smax) begin
      r = smax;
    end
    return r[23:0];
  endfunction

endpackage

@@ sv/nfs_if.sv @@
// ----------------------------------------------------------------------------
// nfs_sample_if / nfs_result_if
// Valid/ready channels for input samples and shifted results.
// ----------------------------------------------------------------------------
interface nfs_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          restart_phase;
  logic                          block_end;

  modport source (output valid, sample_i, sample_q, restart_phase, block_end, input ready);
  modport sink   (input valid, sample_i, sample_q, restart_phase, block_end, output ready);
endinterface

interface nfs_result_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] shifted_i;
  logic signed [SAMPLE_BITS-1:0] shifted_q;
  logic                          block_end_out;

  modport source (output valid, shifted_i, shifted_q, block_end_out, input ready);
  modport sink   (input valid, shifted_i, shifted_q, block_end_out, output ready);
endinterface

@@ sv/nfs_phase_gen.sv @@
// ----------------------------------------------------------------------------
// nfs_phase_gen
// Phase accumulator, increment register and table address generation.
// ----------------------------------------------------------------------------
module nfs_phase_gen
  import nfs_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [31:0]              cfg_wr_data,
  input  nfs_phase_ctl_t           ctl,
  output nfs_quad_t                quad,
  output logic [TABLE_ADDR_BITS-1:0] addr_k,
  output logic [TABLE_ADDR_BITS:0]   addr_nk
);

  localparam logic [TABLE_ADDR_BITS:0] TBL_N = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

  logic [PHASE_BITS-1:0] acc_r;
  logic [PHASE_BITS-1:0] acc_nxt;
  logic [PHASE_BITS-1:0] inc_r;
  logic [PHASE_BITS-1:0] phase_cur;

  assign phase_cur = ctl.restart ? '0 : acc_r;
  assign acc_nxt   = ctl.take ? phase_cur + inc_r : acc_r;
  assign quad      = nfs_quad_t'(phase_cur[PHASE_BITS-1 -: 2]);
  assign addr_k    = phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign addr_nk   = TBL_N - {1'b0, addr_k};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      inc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (cfg_wr_en) begin
        inc_r <= PHASE_BITS'(cfg_wr_data);
      end
    end
  end

  a_restart_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take && ctl.restart && !cfg_wr_en |=> acc_r == $past(inc_r))
    else $error("restart did not leave phase at one increment");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.take |=> $stable(acc_r))
    else $error("phase moved without a request");

endmodule

@@ sv/nfs_sine_rom.sv @@
// ----------------------------------------------------------------------------
// nfs_sine_rom
// Quarter-wave sine table with two registered read ports.
// ----------------------------------------------------------------------------
module nfs_sine_rom
  import nfs_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [TABLE_ADDR_BITS-1:0] addr_a,
  input  logic [TABLE_ADDR_BITS:0]   addr_b,
  output logic [SAMPLE_BITS-1:0]     data_a_r,
  output logic [SAMPLE_BITS-1:0]     data_b_r
);

  localparam int TBL_N = 1 << TABLE_ADDR_BITS;

  logic [SAMPLE_BITS-1:0] rom_tbl [0:TBL_N];

  for (genvar k = 0; k <= TBL_N; k++) begin : g_tbl
    localparam logic [SAMPLE_BITS-1:0] VAL =
      SAMPLE_BITS'(nfs_sine_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS));
    assign rom_tbl[k] = VAL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a_r <= rom_tbl[{1'b0, addr_a}];
      data_b_r <= rom_tbl[addr_b];
    end
  end

endmodule

@@ sv/nfs_mixer.sv @@
// ----------------------------------------------------------------------------
// nfs_mixer
// Complex multiply by the oscillator, round and saturate; three-stage pipe.
// ----------------------------------------------------------------------------
module nfs_mixer
  import nfs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nfs_ctrl_t                     in_ctrl,
  input  logic signed [SAMPLE_BITS-1:0] in_si,
  input  logic signed [SAMPLE_BITS-1:0] in_sq,
  input  nfs_quad_t                     in_quad,
  input  logic [SAMPLE_BITS-1:0]        rom_a,
  input  logic [SAMPLE_BITS-1:0]        rom_b,
  input  logic                          out_ready,
  output logic                          en1,
  output nfs_ctrl_t                     out_ctrl,
  output logic signed [SAMPLE_BITS-1:0] out_re,
  output logic signed [SAMPLE_BITS-1:0] out_im
);

  localparam int PW = 2 * SAMPLE_BITS;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] SMAX_W = SW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SMIN_W = -SMAX_W - SW'(1);
  localparam logic signed [SW-1:0] RND_W  = SW'(64'd1 << (SAMPLE_BITS - 2));

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + RND_W) >>> (SAMPLE_BITS - 1);
    if (r > SMAX_W) begin
      r = SMAX_W;
    end else if (r < SMIN_W) begin
      r = SMIN_W;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  nfs_ctrl_t                     s1_ctrl_r;
  logic signed [SAMPLE_BITS-1:0] si_r;
  logic signed [SAMPLE_BITS-1:0] sq_r;
  nfs_quad_t                     quad_r;

  nfs_ctrl_t                     s2_ctrl_r;
  logic signed [PW-1:0]          p_ic_r;
  logic signed [PW-1:0]          p_qs_r;
  logic signed [PW-1:0]          p_is_r;
  logic signed [PW-1:0]          p_qc_r;

  nfs_ctrl_t                     s3_ctrl_r;
  logic signed [SAMPLE_BITS-1:0] re_r;
  logic signed [SAMPLE_BITS-1:0] im_r;

  logic                          en2;
  logic                          en3;
  logic signed [SAMPLE_BITS-1:0] ta;
  logic signed [SAMPLE_BITS-1:0] tb;
  logic signed [SAMPLE_BITS-1:0] cos_v;
  logic signed [SAMPLE_BITS-1:0] sin_v;
  logic signed [PW-1:0]          p_ic_nxt;
  logic signed [PW-1:0]          p_qs_nxt;
  logic signed [PW-1:0]          p_is_nxt;
  logic signed [PW-1:0]          p_qc_nxt;
  logic signed [SW-1:0]          re_sum;
  logic signed [SW-1:0]          im_sum;

  assign en3 = !s3_ctrl_r.valid || out_ready;
  assign en2 = !s2_ctrl_r.valid || en3;
  assign en1 = !s1_ctrl_r.valid || en2;

  assign ta = signed'(rom_a);
  assign tb = signed'(rom_b);

  always_comb begin
    case (quad_r)
      QUAD_0: begin
        cos_v = tb;
        sin_v = ta;
      end
      QUAD_1: begin
        cos_v = -ta;
        sin_v = tb;
      end
      QUAD_2: begin
        cos_v = -tb;
        sin_v = -ta;
      end
      QUAD_3: begin
        cos_v = ta;
        sin_v = -tb;
      end
    endcase
  end

  assign p_ic_nxt = si_r * cos_v;
  assign p_qs_nxt = sq_r * sin_v;
  assign p_is_nxt = si_r * sin_v;
  assign p_qc_nxt = sq_r * cos_v;

  assign re_sum = SW'(p_ic_r) - SW'(p_qs_r);
  assign im_sum = SW'(p_is_r) + SW'(p_qc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
      s2_ctrl_r <= '0;
      s3_ctrl_r <= '0;
    end else begin
      if (en1) begin
        s1_ctrl_r <= in_ctrl;
      end
      if (en2) begin
        s2_ctrl_r <= s1_ctrl_r;
      end
      if (en3) begin
        s3_ctrl_r <= s2_ctrl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      si_r   <= in_si;
      sq_r   <= in_sq;
      quad_r <= in_quad;
    end
    if (en2) begin
      p_ic_r <= p_ic_nxt;
      p_qs_r <= p_qs_nxt;
      p_is_r <= p_is_nxt;
      p_qc_r <= p_qc_nxt;
    end
    if (en3) begin
      re_r <= round_sat(re_sum);
      im_r <= round_sat(im_sum);
    end
  end

  assign out_ctrl = s3_ctrl_r;
  assign out_re   = re_r;
  assign out_im   = im_r;

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ctrl_r.valid && !en2 |=> s2_ctrl_r.valid && $stable(p_ic_r) && $stable(p_qc_r))
    else $error("stalled product stage changed");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctrl_r.valid && en2 |=> s2_ctrl_r.valid)
    else $error("item lost between table and product stages");

  a_s2_to_s3: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ctrl_r.valid && en3 |=> s3_ctrl_r.valid)
    else $error("item lost between product and result stages");

endmodule

@@ sv/nco_complex_frequency_shifter_core.sv @@
// ----------------------------------------------------------------------------
// nco_complex_frequency_shifter_core
// Complex I/Q frequency shifter driven by a table-based oscillator.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one I/Q sample per request with restart_phase and
//   block_end; out_chan returns one shifted sample per request, in order.
//   cfg_wr_en/cfg_wr_data load the phase increment; write it while idle.
//   Pipeline: three register stages (sine table read, products, round and
//   saturate); a result is valid once it is held in the round and saturate
//   stage, and it leaves when out_chan.ready is high.
//   Throughput: one request per cycle unless out_chan stalls; the two-port
//   registered sine table read and the single phase add never hold the flow.
//   restart_phase clears the phase before that sample; the phase advances
//   by one increment after every accepted sample.
//   Reset clears the phase, the increment and all stage valid bits.
//   When out_chan stalls, stages fill one by one and in_chan.ready drops
//   only once all three stages hold a result; empty stages keep accepting.
// ----------------------------------------------------------------------------
module nco_complex_frequency_shifter_core
  import nfs_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int SAMPLE_BITS     = 16,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  nfs_sample_if.sink   in_chan,
  nfs_result_if.source out_chan
);

  logic                       en1;
  nfs_phase_ctl_t             phase_ctl;
  nfs_quad_t                  quad;
  logic [TABLE_ADDR_BITS-1:0] addr_k;
  logic [TABLE_ADDR_BITS:0]   addr_nk;
  logic [SAMPLE_BITS-1:0]     rom_a;
  logic [SAMPLE_BITS-1:0]     rom_b;
  nfs_ctrl_t                  in_ctrl;
  nfs_ctrl_t                  out_ctrl;

  assign phase_ctl.take    = in_chan.valid && en1;
  assign phase_ctl.restart = in_chan.restart_phase;
  assign in_ctrl.valid     = in_chan.valid;
  assign in_ctrl.block_end = in_chan.block_end;

  nfs_phase_gen #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (phase_ctl),
    .quad        (quad),
    .addr_k      (addr_k),
    .addr_nk     (addr_nk)
  );

  nfs_sine_rom #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk      (clk),
    .en       (en1),
    .addr_a   (addr_k),
    .addr_b   (addr_nk),
    .data_a_r (rom_a),
    .data_b_r (rom_b)
  );

  nfs_mixer #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mixer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctrl   (in_ctrl),
    .in_si     (in_chan.sample_i),
    .in_sq     (in_chan.sample_q),
    .in_quad   (quad),
    .rom_a     (rom_a),
    .rom_b     (rom_b),
    .out_ready (out_chan.ready),
    .en1       (en1),
    .out_ctrl  (out_ctrl),
    .out_re    (out_chan.shifted_i),
    .out_im    (out_chan.shifted_q)
  );

  assign in_chan.ready          = en1;
  assign out_chan.valid         = out_ctrl.valid;
  assign out_chan.block_end_out = out_ctrl.block_end;

endmodule
